// ===== hw/rtl/cns_pkg.sv =====
// Shared types and constants for the cartesian neighbor sorter.
// Used by cns_table, cns_slots and cartesian_neighbor_sorter_top; no dependencies.
`timescale 1ns / 1ps

package cns_pkg;

  localparam int IDX_W    = 16;
  localparam int COORD_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int TOL_W    = 16;
  localparam int SLOT_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE   = 1'b1;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_NEIGHBOR = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]          target;
    logic [IDX_W-1:0]          partner;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]          elem;
    logic [IDX_W-1:0]          nb;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] xn;
    logic signed [COORD_W-1:0] yn;
    logic                      last;
  } probe_t;

  typedef struct packed {
    logic [IDX_W-1:0] element;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] down;
    logic [IDX_W-1:0] up;
  } result_t;

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] sum;
    logic signed [COORD_W-1:0] res;
    sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      res = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res = sum[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/cns_table.sv =====
// Periodic shift table: a synchronous memory with one write and one read port.
// Entry layout comes from cns_pkg.
`timescale 1ns / 1ps

module cns_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cns_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output cns_pkg::entry_t rd_data
);

  cns_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/cns_slots.sv =====
// Neighbor classification and the four direction slots.
// Uses probe_t and result_t from cns_pkg.
`timescale 1ns / 1ps

module cns_slots (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         upd,
  input  cns_pkg::probe_t              probe,
  input  logic [cns_pkg::TOL_W-1:0]    tol,
  output cns_pkg::result_t             res
);

  localparam int NB = 4;

  logic [cns_pkg::IDX_W-1:0] value [NB];
  logic [NB-1:0]             filled;
  logic [cns_pkg::IDX_W-1:0] value_next [NB];
  logic [NB-1:0]             filled_next;
  logic signed [cns_pkg::COORD_W:0] dxs;
  logic signed [cns_pkg::COORD_W:0] dys;
  logic [cns_pkg::COORD_W:0] adx;
  logic [cns_pkg::COORD_W:0] ady;
  logic xeq;
  logic yeq;
  logic [NB-1:0] hit;
  logic [cns_pkg::IDX_W-1:0] outv [NB];

  always_comb begin
    dxs = {probe.xn[cns_pkg::COORD_W-1], probe.xn} - {probe.x[cns_pkg::COORD_W-1], probe.x};
    dys = {probe.yn[cns_pkg::COORD_W-1], probe.yn} - {probe.y[cns_pkg::COORD_W-1], probe.y};
    adx = dxs[cns_pkg::COORD_W] ? -dxs : dxs;
    ady = dys[cns_pkg::COORD_W] ? -dys : dys;
    xeq = adx <= {{(cns_pkg::COORD_W + 1 - cns_pkg::TOL_W){1'b0}}, tol};
    yeq = ady <= {{(cns_pkg::COORD_W + 1 - cns_pkg::TOL_W){1'b0}}, tol};
    hit = '0;
    if (yeq && probe.x > probe.xn) begin
      hit[0] = 1'b1;
    end else if (yeq && probe.x < probe.xn) begin
      hit[1] = 1'b1;
    end else if (xeq && probe.y > probe.yn) begin
      hit[2] = 1'b1;
    end else if (xeq && probe.y < probe.yn) begin
      hit[3] = 1'b1;
    end
    for (int k = 0; k < NB; k++) begin
      value_next[k]  = hit[k] ? probe.nb : value[k];
      filled_next[k] = hit[k] | filled[k];
      outv[k]        = filled_next[k] ? value_next[k] : probe.elem;
    end
    res.element = probe.elem;
    res.left    = outv[0];
    res.right   = outv[1];
    res.down    = outv[2];
    res.up      = outv[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (upd) begin
      filled <= probe.last ? '0 : filled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int k = 0; k < NB; k++) begin
        value[k] <= value_next[k];
      end
    end
  end

endmodule

// ===== hw/rtl/cartesian_neighbor_sorter_top.sv =====
// Top level of the cartesian neighbor sorter.
// Depends on cns_pkg, cns_table and cns_slots.
`timescale 1ns / 1ps
//
// Usage:
// The input channel (in_valid/in_stall) carries one item per transaction.
// A mode 0 item writes one entry of the periodic shift table.
// A mode 1 item presents one neighbor of an element; the block scans the
// shift table from entry 0, one entry per cycle through the single read
// port, stops at the first matching entry and applies its shift. When
// none of the valid entries matches, the scan ends after the last of them
// and no shift is applied; at most MAX_SHIFT_ENTRIES entries are scanned.
// An item with last_neighbor set produces one transaction on the output
// channel (out_valid/out_stall) holding the element and its left, right,
// down and up neighbors; it appears in the cycle after the final step.
// The output register lets the next item be accepted while a result waits;
// a final neighbor holds in its last step while an older result is stalled.
// The configuration port (cfg_valid/cfg_ready) is always ready and must be
// written only while the block is idle. Reset clears both registers, the
// slots and the output channel; table contents are undefined until written.

module cartesian_neighbor_sorter_top #(
  parameter int MAX_SHIFT_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [cns_pkg::SLOT_W-1:0]          entry_slot,
  input  logic [cns_pkg::IDX_W-1:0]           element_index,
  input  logic [cns_pkg::IDX_W-1:0]           neighbor_index,
  input  logic signed [cns_pkg::COORD_W-1:0]  elem_x,
  input  logic signed [cns_pkg::COORD_W-1:0]  elem_y,
  input  logic signed [cns_pkg::COORD_W-1:0]  nb_x,
  input  logic signed [cns_pkg::COORD_W-1:0]  nb_y,
  input  logic signed [cns_pkg::COORD_W-1:0]  shift_x,
  input  logic signed [cns_pkg::COORD_W-1:0]  shift_y,
  input  logic                                last_neighbor,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cns_pkg::IDX_W-1:0]           out_element,
  output logic [cns_pkg::IDX_W-1:0]           left_index,
  output logic [cns_pkg::IDX_W-1:0]           right_index,
  output logic [cns_pkg::IDX_W-1:0]           down_index,
  output logic [cns_pkg::IDX_W-1:0]           up_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cns_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cns_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW   = (MAX_SHIFT_ENTRIES > 1) ? $clog2(MAX_SHIFT_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_SHIFT_ENTRIES + 1);
  localparam int CMPW = (CW > cns_pkg::COUNT_W) ? CW : cns_pkg::COUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_CLASS = 4'b1000
  } state_t;

  state_t state;
  logic [cns_pkg::COUNT_W-1:0] shift_entry_count;
  logic [cns_pkg::TOL_W-1:0]   match_tolerance;
  logic [CMPW-1:0]             count_eff;
  logic [CW-1:0]               scan_addr;
  logic                        pend;
  cns_pkg::probe_t             cur;
  logic signed [cns_pkg::COORD_W-1:0] shift_dx;
  logic signed [cns_pkg::COORD_W-1:0] shift_dy;

  logic            in_take;
  logic            tbl_wr_en;
  logic [AW+cns_pkg::SLOT_W-1:0] slot_ext;
  cns_pkg::entry_t wr_entry;
  cns_pkg::entry_t rd_entry;
  logic            issue;
  logic            hit;
  logic            class_go;
  logic            emit;
  cns_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;

  assign count_eff = (CMPW'(shift_entry_count) > CMPW'(MAX_SHIFT_ENTRIES))
                   ? CMPW'(MAX_SHIFT_ENTRIES) : CMPW'(shift_entry_count);

  assign slot_ext  = {{AW{1'b0}}, entry_slot};
  assign tbl_wr_en = in_take && (mode == cns_pkg::MODE_LOAD)
                   && (CMPW'(entry_slot) < CMPW'(MAX_SHIFT_ENTRIES));
  assign wr_entry  = '{target: element_index, partner: neighbor_index,
                       dx: shift_x, dy: shift_y};

  assign issue = (state == ST_SCAN) && (CMPW'(scan_addr) < count_eff);
  assign hit   = pend && (rd_entry.target == cur.elem) && (rd_entry.partner == cur.nb);

  assign class_go = (state == ST_CLASS) && !(cur.last && out_valid && out_stall);
  assign emit     = class_go && cur.last;

  cns_table #(
    .DEPTH (MAX_SHIFT_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (scan_addr[AW-1:0]),
    .rd_data (rd_entry)
  );

  cns_slots u_slots (
    .clk   (clk),
    .rst   (rst),
    .upd   (class_go),
    .probe (cur),
    .tol   (match_tolerance),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_entry_count <= '0;
      match_tolerance   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cns_pkg::REG_SHIFT_ENTRY_COUNT: shift_entry_count <= cfg_data[cns_pkg::COUNT_W-1:0];
        cns_pkg::REG_MATCH_TOLERANCE:   match_tolerance   <= cfg_data[cns_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      scan_addr <= '0;
    end else begin
      pend <= issue;
      case (state)
        ST_IDLE: begin
          scan_addr <= '0;
          if (in_take && mode == cns_pkg::MODE_NEIGHBOR) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + CW'(1);
          end
          if (hit || (!issue && !pend)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          state <= ST_CLASS;
        end
        ST_CLASS: begin
          if (class_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && mode == cns_pkg::MODE_NEIGHBOR) begin
      cur <= '{elem: element_index, nb: neighbor_index, x: elem_x, y: elem_y,
               xn: nb_x, yn: nb_y, last: last_neighbor};
    end else if (state == ST_ADD) begin
      cur.xn <= cns_pkg::sat_add(cur.xn, shift_dx);
      cur.yn <= cns_pkg::sat_add(cur.yn, shift_dy);
    end
    if (state == ST_SCAN) begin
      if (hit) begin
        shift_dx <= rd_entry.dx;
        shift_dy <= rd_entry.dy;
      end else if (!issue && !pend) begin
        shift_dx <= '0;
        shift_dy <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_element <= res.element;
      left_index  <= res.left;
      right_index <= res.right;
      down_index  <= res.down;
      up_index    <= res.up;
    end
  end

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !tbl_wr_en)
    else $error("shift table written while an item is in flight");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (CMPW'(scan_addr) < CMPW'(MAX_SHIFT_ENTRIES)))
    else $error("shift table read beyond its depth");

  a_emit_from_class: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_CLASS && cur.last))
    else $error("result raised outside the final step of a last neighbor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !emit)
    else $error("stalled result overwritten");

endmodule
